// ===== sv/ecs_pkg.sv =====
package ecs_pkg;

    // Input word: one energy sample or one decide request
    typedef struct packed {
        logic       req_type;
        logic [3:0] channel_index;
        logic [7:0] energy;
    } req_t;

    // Output word: one per input word
    typedef struct packed {
        logic [3:0] operating_channel;
        logic       switch_made;
        logic       decision_done;
    } res_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DECIDE = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_MARGIN        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NONPREFERRED_PENALTY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFERRED_MASK       = 2'd3;

    // Configuration reset values
    localparam logic [8:0]  WEIGHT_RESET  = 9'd166;
    localparam logic [7:0]  MARGIN_RESET  = 8'd5;
    localparam logic [7:0]  PENALTY_RESET = 8'd8;
    localparam logic [15:0] MASK_RESET    = 16'h4210;
    localparam logic [8:0]  WEIGHT_ONE    = 9'd256;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic smp_read;
        logic smp_mix;
        logic smp_write;
        logic scan_clear;
        logic scan_read;
        logic apply;
        logic post;
    } ecs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_decide;
        logic in_range;
        logic scan_last;
    } ecs_stat_t;

endpackage

// ===== sv/ecs_datapath.sv =====
module ecs_datapath #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ecs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ecs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  ecs_pkg::req_t                  req_word,
    input  ecs_pkg::ecs_cmd_t              cmd,
    output ecs_pkg::ecs_stat_t             stat,
    output ecs_pkg::res_t                  res_word
);
    import ecs_pkg::*;

    localparam int CW = $clog2(NUM_CHANNELS);

    // Configuration
    logic [8:0]  weight_reg;
    logic [7:0]  margin_reg;
    logic [7:0]  penalty_reg;
    logic [15:0] mask_reg;

    // Captured word
    logic        kind_reg;
    logic [3:0]  chan_reg;
    logic [7:0]  energy_reg;
    logic        in_range_reg;

    // Score store
    logic [15:0]             score_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [15:0]             rd_data_reg;
    logic [CW-1:0]           rd_addr;
    logic [CW-1:0]           smp_addr;

    // Blend
    logic [8:0]  w_eff;
    logic [8:0]  w_inv;
    logic [16:0] prod_new_reg;
    logic [24:0] prod_old_reg;
    logic [17:0] mix_sum;
    logic [15:0] write_val;

    // Scan
    logic [CW-1:0] scan_cnt_reg;
    logic [CW-1:0] cmp_idx_reg;
    logic          pend_reg;
    logic          found_reg;
    logic [CW-1:0] best_idx_reg;
    logic [16:0]   best_total_reg;
    logic [15:0]   cur_score_reg;
    logic [3:0]    cur_chan_reg;
    logic          sw_reg;
    logic          scan_last;
    logic          pref;
    logic [16:0]   total;
    logic          cmp_ok;
    logic          take;
    logic          at_current;
    logic [17:0]   thresh;
    logic          stay;
    res_t          res_reg;

    assign smp_addr  = CW'(chan_reg);
    assign rd_addr   = cmd.scan_read ? scan_cnt_reg : smp_addr;
    assign scan_last = (scan_cnt_reg == CW'(NUM_CHANNELS - 1));

    assign w_eff     = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_inv     = WEIGHT_ONE - w_eff;
    // (w*e*256 + (256-w)*old) >> 8 == w*e + ((256-w)*old >> 8)
    assign mix_sum   = {1'b0, prod_new_reg} + {1'b0, prod_old_reg[24:8]};
    assign write_val = valid_reg[smp_addr] ? mix_sum[15:0] : {energy_reg, 8'd0};

    assign pref       = (32'(cmp_idx_reg) < 32'd16) && mask_reg[4'(cmp_idx_reg)];
    assign total      = {1'b0, rd_data_reg} + (pref ? 17'd0 : {1'b0, penalty_reg, 8'd0});
    assign cmp_ok     = pend_reg && valid_reg[cmp_idx_reg];
    assign take       = cmp_ok && (!found_reg || (total < best_total_reg));
    assign at_current = pend_reg && (32'(cmp_idx_reg) == 32'(cur_chan_reg));

    assign thresh = {1'b0, best_total_reg} + {2'b00, margin_reg, 8'd0};
    assign stay   = !found_reg || ({2'b00, cur_score_reg} < thresh)
                    || (32'(best_idx_reg) == 32'(cur_chan_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= WEIGHT_RESET;
            margin_reg   <= MARGIN_RESET;
            penalty_reg  <= PENALTY_RESET;
            mask_reg     <= MASK_RESET;
            valid_reg    <= '0;
            in_range_reg <= 1'b0;
            kind_reg     <= REQ_SAMPLE;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            cur_chan_reg <= 4'd0;
            sw_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SMOOTHING_WEIGHT:     weight_reg  <= cfg_wdata[8:0];
                    REG_SWITCH_MARGIN:        margin_reg  <= cfg_wdata[7:0];
                    REG_NONPREFERRED_PENALTY: penalty_reg <= cfg_wdata[7:0];
                    REG_PREFERRED_MASK:       mask_reg    <= cfg_wdata;
                endcase
            end
            if (cmd.capture)
            begin
                kind_reg     <= req_word.req_type;
                in_range_reg <= 32'(req_word.channel_index) < 32'(NUM_CHANNELS);
                sw_reg       <= 1'b0;
            end
            if (cmd.smp_write)
                valid_reg[smp_addr] <= 1'b1;
            pend_reg <= cmd.scan_read;
            if (cmd.scan_clear)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_read && !scan_last)
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (take)
                    found_reg <= 1'b1;
            end
            if (cmd.apply && !stay)
            begin
                cur_chan_reg <= 4'(best_idx_reg);
                sw_reg       <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            chan_reg   <= req_word.channel_index;
            energy_reg <= req_word.energy;
        end
        if (cmd.smp_read)
            prod_new_reg <= {8'd0, w_eff} * {9'd0, energy_reg};
        if (cmd.smp_mix)
            prod_old_reg <= {16'd0, w_inv} * {9'd0, rd_data_reg};
        cmp_idx_reg <= scan_cnt_reg;
        if (cmd.scan_clear)
            cur_score_reg <= 16'd0;
        else if (at_current)
            cur_score_reg <= valid_reg[cmp_idx_reg] ? rd_data_reg : 16'd0;
        if (take)
        begin
            best_total_reg <= total;
            best_idx_reg   <= cmp_idx_reg;
        end
        if (cmd.post)
        begin
            res_reg.operating_channel <= cur_chan_reg;
            res_reg.switch_made       <= sw_reg;
            res_reg.decision_done     <= kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.smp_write)
            score_mem[smp_addr] <= write_val;
        rd_data_reg <= score_mem[rd_addr];
    end

    assign stat.is_decide = (kind_reg == REQ_DECIDE);
    assign stat.in_range  = in_range_reg;
    assign stat.scan_last = scan_last;
    assign res_word       = res_reg;

endmodule

// ===== sv/ecs_ctrl.sv =====
module ecs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    output logic                  res_valid,
    input  logic                  res_stall,
    input  ecs_pkg::ecs_stat_t    stat,
    output ecs_pkg::ecs_cmd_t     cmd
);
    import ecs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SMP_RD,
        ST_SMP_MIX,
        ST_SMP_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_decide)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (stat.in_range)
                    state_next = ST_SMP_RD;
                else
                    state_next = ST_FINISH;
            end
            ST_SMP_RD:
            begin
                cmd.smp_read = 1'b1;
                state_next   = ST_SMP_MIX;
            end
            ST_SMP_MIX:
            begin
                cmd.smp_mix = 1'b1;
                state_next  = ST_SMP_WR;
            end
            ST_SMP_WR:
            begin
                cmd.smp_write = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (stat.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_APPLY;
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign res_valid_next = (res_valid_reg && res_stall) || cmd.post;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// ===== sv/ewma_channel_selector_core.sv =====
// Channel  | Direction | Handshake            | Word
// req      | in        | req_valid/req_stall  | req_word (sample or decide)
// res      | out       | res_valid/res_stall  | res_word (one per req word)
// cfg      | in        | cfg_we               | cfg_index, cfg_wdata
//
// An in-range sample word is read, blended and written back before its
// result is posted; a decide word scans the scores, one score per cycle
// through the single read port of the score memory.
// Reset clears the valid bits and the operating channel and returns the
// configuration to its reset values; score memory contents are not cleared,
// an invalid entry reads as zero.
// A waiting result does not block the next accept; a result that finds the
// output register still stalled holds in the controller until it drains.
module ewma_channel_selector_core #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ecs_pkg::req_t                   req_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ecs_pkg::res_t                   res_word,
    input  logic                            cfg_we,
    input  logic [ecs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ecs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ecs_pkg::*;

    ecs_cmd_t  cmd;
    ecs_stat_t stat;

    // Sequence each word: capture, blend or scan, then post the result
    ecs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold scores, configuration, the running minimum and the output register
    ecs_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .res_word  (res_word)
    );

endmodule

// ===== sv/ecs_checker.sv =====
module ecs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          res_valid,
    input logic          res_stall,
    input ecs_pkg::res_t res_word
);
    import ecs_pkg::*;

    // Stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // One word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("accepted a second word while busy");

    // A result only appears after the block was working
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result appeared without a word in work");

    // Only a decide can switch
    a_switch_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.switch_made |-> res_word.decision_done)
        else $error("switch reported on a sample word");

endmodule

bind ewma_channel_selector_core ecs_checker u_ecs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
);

// ===== test/ewma_channel_selector_core_tb.sv =====
module ewma_channel_selector_core_tb;
    import ecs_pkg::*;

    localparam int NUM_CH          = 16;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int IDLE_PCT        = 37;
    localparam int HOLD_CYCLES     = 90;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 100;
    localparam int CALM_PHASE      = 4;
    localparam int HOLD_PHASE      = 5;

    // Mirror of the selector: per-channel smoothed scores, the operating
    // channel and the settings, plus the results still owed by the block.
    class channel_selector_mirror;
        logic [15:0] score [NUM_CH];
        bit          loaded [NUM_CH];
        logic [3:0]  on_channel;
        logic [8:0]  weight;
        logic [7:0]  margin;
        logic [7:0]  penalty;
        logic [15:0] pref_mask;
        res_t        channel_reports [$];
        int          mismatches;
        int          samples;
        int          decides;
        int          switches;

        function new();
            for (int i = 0; i < NUM_CH; i++)
            begin
                score[i]  = '0;
                loaded[i] = 1'b0;
            end
            on_channel = '0;
            weight     = WEIGHT_RESET;
            margin     = MARGIN_RESET;
            penalty    = PENALTY_RESET;
            pref_mask  = MASK_RESET;
            mismatches = 0;
            samples    = 0;
            decides    = 0;
            switches   = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SMOOTHING_WEIGHT:     weight    = data[8:0];
                REG_SWITCH_MARGIN:        margin    = data[7:0];
                REG_NONPREFERRED_PENALTY: penalty   = data[7:0];
                REG_PREFERRED_MASK:       pref_mask = data;
                default: ;
            endcase
        endfunction

        // Advance the mirror by one accepted word and queue the result it owes.
        function void note_word(req_t w);
            res_t        r;
            int unsigned eff_weight;
            int unsigned blend;
            int unsigned total;
            int unsigned best_total;
            int unsigned cur_score;
            logic [3:0]  best;
            bit          found;
            r.switch_made   = 1'b0;
            r.decision_done = (w.req_type == REQ_DECIDE);
            if (w.req_type == REQ_SAMPLE)
            begin
                samples++;
                if (!loaded[w.channel_index])
                begin
                    score[w.channel_index]  = {w.energy, 8'h00};
                    loaded[w.channel_index] = 1'b1;
                end
                else
                begin
                    // clamp weights above one, then blend and truncate
                    eff_weight = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
                    blend = eff_weight * {w.energy, 8'h00}
                          + (256 - eff_weight) * score[w.channel_index];
                    score[w.channel_index] = 16'(blend >> 8);
                end
            end
            else
            begin
                decides++;
                found      = 1'b0;
                best       = on_channel;
                best_total = 0;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (loaded[i])
                    begin
                        total = score[i] + (pref_mask[i] ? 0 : {penalty, 8'h00});
                        if (!found || total < best_total)
                        begin
                            best_total = total;
                            best       = 4'(i);
                            found      = 1'b1;
                        end
                    end
                end
                // an unloaded current channel reads as zero, which the array keeps
                if (found)
                begin
                    cur_score = score[on_channel];
                    if (cur_score >= best_total + {margin, 8'h00} && best != on_channel)
                    begin
                        on_channel    = best;
                        r.switch_made = 1'b1;
                        switches++;
                    end
                end
            end
            r.operating_channel = on_channel;
            channel_reports.insert(channel_reports.size(), r);
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (channel_reports.size() == 0)
            begin
                $display("%0t: expected no result, actual ch=%0d switch=%0b done=%0b", $time,
                         got.operating_channel, got.switch_made, got.decision_done);
                mismatches++;
            end
            else
            begin
                want = channel_reports.pop_front();
                if (got.operating_channel !== want.operating_channel)
                begin
                    $display("%0t: operating_channel expected %0d actual %0d", $time,
                             want.operating_channel, got.operating_channel);
                    mismatches++;
                end
                if (got.switch_made !== want.switch_made)
                begin
                    $display("%0t: switch_made expected %0b actual %0b", $time,
                             want.switch_made, got.switch_made);
                    mismatches++;
                end
                if (got.decision_done !== want.decision_done)
                begin
                    $display("%0t: decision_done expected %0b actual %0b", $time,
                             want.decision_done, got.decision_done);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req_word  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_t                   res_word;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    channel_selector_mirror mirror;
    bit     calm        = 1'b0;  // no idling on either side while set
    int     holds_asked = 0;     // long receiver hold-offs requested
    int     holds_done  = 0;
    int     hold_left   = 0;
    int     settings    = 0;
    longint cycle_count = 0;

    ewma_channel_selector_core #(
        .NUM_CHANNELS(NUM_CH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Receiver: stall at random, drop to no stall in the calm phase, and
    // serve a long hold-off when one is requested, so the block backs up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (calm)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Check every result word taken at a rising edge; bound the run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     mirror.channel_reports.size());
            $display("simulation failed");
            $finish;
        end
        else if (rst_n && res_valid && !res_stall)
            mirror.check_word(res_word);
    end

    // Offer one word, maybe after a random gap, and hold it until accepted.
    task automatic send_word(input req_t w);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        mirror.note_word(w);
    endtask

    task automatic send_sample(input logic [3:0] ch, input logic [7:0] e);
        req_t w;
        w.req_type      = REQ_SAMPLE;
        w.channel_index = ch;
        w.energy        = e;
        send_word(w);
    endtask

    // Channel and energy ride along on a decide but must be ignored.
    task automatic send_decide(input logic [3:0] ch, input logic [7:0] e);
        req_t w;
        w.req_type      = REQ_DECIDE;
        w.channel_index = ch;
        w.energy        = e;
        send_word(w);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (mirror.channel_reports.size() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        mirror.write_reg(idx, data);
    endtask

    // Write all four registers; junk in the unused upper bits must be dropped.
    task automatic load_settings(input logic [8:0] w, input logic [7:0] m,
                                 input logic [7:0] p, input logic [15:0] mask);
        put_reg(REG_SMOOTHING_WEIGHT, {7'($urandom), w});
        put_reg(REG_SWITCH_MARGIN, {8'($urandom), m});
        put_reg(REG_NONPREFERRED_PENALTY, {8'($urandom), p});
        put_reg(REG_PREFERRED_MASK, mask);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Scan-shaped traffic: a burst of samples closed by a decide, with the
    // odd extra decide back to back.
    task automatic run_scans(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                send_sample(4'($urandom),
                            ($urandom_range(0, 4) == 0) ?
                                ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
                sent++;
            end
            send_decide(4'($urandom), 8'($urandom));
            sent++;
            if ($urandom_range(0, 9) == 0)
            begin
                send_decide(4'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        mirror = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: decide with nothing loaded, with junk fields, then
        // load a preferred channel at zero, too close to switch away from.
        send_decide(4'd15, 8'hFF);
        send_sample(4'd4, 8'd0);
        send_decide(4'd0, 8'd0);
        drain();

        // Zero margin: the unloaded current channel reads zero and loses to
        // the zero-score channel; the next decide finds the winner current.
        load_settings(WEIGHT_RESET, 8'd0, PENALTY_RESET, MASK_RESET);
        send_decide(4'd0, 8'd0);
        send_decide(4'd9, 8'h5A);
        send_sample(4'd15, 8'hFF);
        send_sample(4'd15, 8'd0);
        send_sample(4'd0, 8'hFF);
        send_sample(4'd4, 8'hFF);
        send_decide(4'd0, 8'd0);
        send_decide(4'd0, 8'd0);
        drain();

        // Top of every range, weight past one which must clamp.
        load_settings(9'h1FF, 8'hFF, 8'hFF, 16'hFFFF);
        send_sample(4'd15, 8'hFF);
        send_sample(4'd0, 8'd0);
        send_sample(4'd15, 8'hFF);
        send_decide(4'd15, 8'hFF);
        drain();

        // Bottom of every range: zero weight freezes loaded scores.
        load_settings(9'd0, 8'd0, 8'd0, 16'h0000);
        send_sample(4'd0, 8'd200);
        send_sample(4'd7, 8'd1);
        send_decide(4'd0, 8'd0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(WEIGHT_RESET, MARGIN_RESET, PENALTY_RESET, MASK_RESET);
                1: load_settings(WEIGHT_ONE, 8'd0, 8'd0, 16'h0000);
                2: load_settings(9'd0, 8'hFF, 8'hFF, 16'hFFFF);
                3: load_settings(9'($urandom_range(257, 511)), 8'($urandom_range(0, 8)),
                                 8'($urandom_range(0, 16)), 16'($urandom));
                default: load_settings(9'($urandom_range(0, 256)), 8'($urandom_range(0, 12)),
                                       8'($urandom_range(0, 24)), 16'($urandom));
            endcase
            calm = (ph == CALM_PHASE);
            if (ph == HOLD_PHASE)
                holds_asked++;
            run_scans(WORDS_PER_PHASE);
            drain();
        end
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d samples and %0d decides (%0d switches) over %0d settings,",
                 mirror.samples, mirror.decides, mirror.switches, settings);
        $display("with random stalls, a calm stretch and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mirror.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
